[hw/rtl/tftpsc_pkg.sv]
// Shared codes, defaults and types for the TFTP transfer controller.
package tftpsc_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;

  // input word kinds
  localparam logic [1:0] FUNC_PACKET = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_FILE   = 2'd2;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  // TFTP opcodes
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // commands
  localparam logic [2:0] CMD_DATA    = 3'd0;
  localparam logic [2:0] CMD_ACK     = 3'd1;
  localparam logic [2:0] CMD_ERROR   = 3'd2;
  localparam logic [2:0] CMD_OPEN_RD = 3'd3;
  localparam logic [2:0] CMD_OPEN_WR = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;
  localparam logic [2:0] CMD_WRITE   = 3'd6;

  // TFTP error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
  localparam logic [2:0] ERR_ACCESS    = 3'd2;
  localparam logic [2:0] ERR_FULL      = 3'd3;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd4;
  localparam logic [2:0] ERR_BAD_BLOCK = 3'd5;

  // finish codes
  localparam logic [1:0] FIN_GO   = 2'd0;
  localparam logic [1:0] FIN_DONE = 2'd1;
  localparam logic [1:0] FIN_FAIL = 2'd3;

  // transfer mode
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // pending file-side request
  localparam logic [2:0] AW_NONE    = 3'd0;
  localparam logic [2:0] AW_OPEN_RD = 3'd1;
  localparam logic [2:0] AW_OPEN_WR = 3'd2;
  localparam logic [2:0] AW_READ    = 3'd3;
  localparam logic [2:0] AW_WRITE   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_READ_ONLY   = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [3:0] MAX_RETRIES_RST = 4'd5;
  localparam logic [7:0] TIMEOUT_RST     = 8'd10;
  localparam logic [7:0] TICK_SAT        = 8'hFF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] blk;
    logic [9:0]  len;
    logic [2:0]  err;
    logic        snd;
    logic [1:0]  fin;
  } res_t;

endpackage

[hw/rtl/tftp_server_transfer_control.sv]
// TFTP server transfer controller: one transfer at a time, at most one command per word.
//
// Usage:
//   in_*  : one word per event. in_func selects packet header, one-second
//           tick or file-side reply; the other fields carry that event.
//   out_* : at most one command word per input word (send DATA/ACK/ERROR,
//           open read/write, read block, write payload) plus finish status.
//   cfg_* : register writes (0 read_only, 1 max_retries, 2 timeout_ticks),
//           always ready; write only while no word is in flight.
// Timing: an accepted word waits in the input register; its command and
//   the new transfer state are written together into the result and state
//   registers when the word moves on. The decode is a single short pass, so
//   one word per cycle is sustained while out_ready does not hold a command.
// Stall: while a command waits on out_ready the input register holds its
//   word; in_ready drops only when that register is full and cannot move.
//   Words that make no command pass through even then only if the output is
//   free, keeping order simple.
// Reset (rst_n low, synchronous): mode idle, no file request pending,
//   block 1, counters and last length zero, registers at their defaults.
module tftp_server_transfer_control
  import tftpsc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_block_number,
  input  logic [9:0]  in_packet_length,
  input  logic        in_from_peer,
  input  logic        in_request_valid,
  input  logic        in_file_ok,
  input  logic        in_disk_full,
  input  logic [9:0]  in_read_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_command,
  output logic [15:0] out_out_block,
  output logic [9:0]  out_send_length,
  output logic [2:0]  out_error_code,
  output logic        out_to_sender,
  output logic [1:0]  out_finish,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // block size, one bit wider so 1024 still compares correctly
  localparam logic [10:0] BB     = 11'(BLOCK_BYTES);
  localparam logic [9:0]  BB_LEN = BB[9:0];

  // configuration
  logic       read_only_r;
  logic [3:0] max_retries_r;
  logic [7:0] timeout_r;

  // input register
  logic        s1_v_r;
  logic [1:0]  func_r;
  logic [15:0] op_r;
  logic [15:0] blk_r;
  logic [9:0]  plen_r;
  logic        peer_r;
  logic        reqv_r;
  logic        ok_r;
  logic        full_r;
  logic [9:0]  rlen_r;

  // transfer state
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  aw_r, aw_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [9:0]  last_r, last_nxt;

  // result register
  logic out_v_r;
  res_t out_r;

  // decode
  logic        res_v;
  res_t        res;
  logic        fail_v;
  logic [2:0]  fail_err;
  logic [9:0]  pay;
  logic [9:0]  pay_sat;
  logic [9:0]  rlen_sat;
  logic [7:0]  tick_inc;
  logic [15:0] cur_inc;
  logic        advance;

  assign advance   = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || advance;
  assign cfg_ready = 1'b1;

  assign pay      = plen_r - 10'd4;
  assign pay_sat  = ({1'b0, pay} > BB) ? BB_LEN : pay;
  assign rlen_sat = ({1'b0, rlen_r} > BB) ? BB_LEN : rlen_r;
  assign tick_inc = (tick_r == TICK_SAT) ? tick_r : tick_r + 8'd1;
  assign cur_inc  = cur_r + 16'd1;

  always_comb begin
    mode_nxt  = mode_r;
    aw_nxt    = aw_r;
    cur_nxt   = cur_r;
    retry_nxt = retry_r;
    tick_nxt  = tick_r;
    last_nxt  = last_r;
    res_v     = 1'b0;
    res       = '0;
    fail_v    = 1'b0;
    fail_err  = ERR_NONE;

    if (s1_v_r) begin
      priority if (func_r == FUNC_FILE) begin
        aw_nxt = AW_NONE;
        unique case (aw_r)
          AW_OPEN_RD: begin
            if (!ok_r) begin
              fail_v = 1'b1; fail_err = ERR_NOT_FOUND;
            end else begin
              aw_nxt  = AW_READ;
              res_v   = 1'b1;
              res.cmd = CMD_READ;
              res.blk = cur_r;
            end
          end
          AW_OPEN_WR: begin
            if (!ok_r) begin
              fail_v = 1'b1; fail_err = ERR_NOT_FOUND;
            end else begin
              retry_nxt = '0;
              tick_nxt  = '0;
              res_v     = 1'b1;
              res.cmd   = CMD_ACK;
            end
          end
          AW_READ: begin
            if (!ok_r) begin
              fail_v = 1'b1; fail_err = ERR_ACCESS;
            end else begin
              last_nxt  = rlen_sat;
              retry_nxt = '0;
              tick_nxt  = '0;
              res_v     = 1'b1;
              res.cmd   = CMD_DATA;
              res.blk   = cur_r;
              res.len   = rlen_sat;
            end
          end
          AW_WRITE: begin
            if (!ok_r) begin
              fail_v   = 1'b1;
              fail_err = full_r ? ERR_FULL : ERR_ACCESS;
            end else begin
              retry_nxt = '0;
              tick_nxt  = '0;
              res_v     = 1'b1;
              res.cmd   = CMD_ACK;
              res.blk   = cur_r;
              if ({1'b0, last_r} < BB) begin
                mode_nxt = MODE_IDLE;
                res.fin  = FIN_DONE;
              end else begin
                cur_nxt = cur_inc;
              end
            end
          end
          default: ;  // unsolicited reply
        endcase
      end else if (func_r == FUNC_SPARE || aw_r != AW_NONE) begin
        // reserved kind, or waiting on the file side
      end else if (mode_r == MODE_IDLE) begin
        if (func_r == FUNC_PACKET && plen_r >= 10'd4) begin
          if (op_r == OP_RRQ || op_r == OP_WRQ) begin
            if (!reqv_r || (op_r == OP_WRQ && read_only_r)) begin
              res_v   = 1'b1;
              res.cmd = CMD_ERROR;
              res.err = ERR_ACCESS;
              res.fin = FIN_FAIL;
            end else begin
              mode_nxt  = (op_r == OP_RRQ) ? MODE_READ : MODE_WRITE;
              aw_nxt    = (op_r == OP_RRQ) ? AW_OPEN_RD : AW_OPEN_WR;
              cur_nxt   = 16'd1;
              retry_nxt = '0;
              tick_nxt  = '0;
              last_nxt  = '0;
              res_v     = 1'b1;
              res.cmd   = (op_r == OP_RRQ) ? CMD_OPEN_RD : CMD_OPEN_WR;
            end
          end else if (op_r == OP_DATA || op_r == OP_ACK) begin
            res_v   = 1'b1;
            res.cmd = CMD_ERROR;
            res.err = ERR_ACCESS;
          end else if (op_r != OP_ERROR) begin
            res_v   = 1'b1;
            res.cmd = CMD_ERROR;
            res.err = ERR_ILLEGAL;
          end
        end
      end else if (func_r == FUNC_PACKET) begin
        tick_nxt = '0;
        priority if (!peer_r) begin
          res_v   = 1'b1;
          res.cmd = CMD_ERROR;
          res.err = ERR_ACCESS;
          res.snd = 1'b1;
        end else if (plen_r < 10'd4) begin
          // runt from the peer
        end else if (op_r == OP_ERROR) begin
          mode_nxt = MODE_IDLE;
        end else if (mode_r == MODE_READ) begin
          if (op_r != OP_ACK) begin
            fail_v = 1'b1; fail_err = ERR_ILLEGAL;
          end else if (blk_r == cur_r) begin
            if ({1'b0, last_r} < BB) begin
              mode_nxt = MODE_IDLE;
            end else begin
              cur_nxt = cur_inc;
              aw_nxt  = AW_READ;
              res_v   = 1'b1;
              res.cmd = CMD_READ;
              res.blk = cur_inc;
            end
          end
        end else begin
          if (op_r != OP_DATA) begin
            fail_v = 1'b1; fail_err = ERR_ILLEGAL;
          end else if (blk_r == cur_r) begin
            last_nxt = pay_sat;
            aw_nxt   = AW_WRITE;
            res_v    = 1'b1;
            res.cmd  = CMD_WRITE;
            res.blk  = cur_r;
            res.len  = pay_sat;
          end else if (blk_r + 16'd1 == cur_r) begin
            // duplicate of the previous block: ACK it again
            res_v   = 1'b1;
            res.cmd = CMD_ACK;
            res.blk = blk_r;
          end else begin
            fail_v = 1'b1; fail_err = ERR_BAD_BLOCK;
          end
        end
      end else begin
        // one-second tick during a transfer
        if (tick_inc < timeout_r) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt = '0;
          if (retry_r >= max_retries_r) begin
            mode_nxt = MODE_IDLE;
          end else begin
            retry_nxt = retry_r + 4'd1;
            res_v     = 1'b1;
            if (mode_r == MODE_READ) begin
              res.cmd = CMD_DATA;
              res.blk = cur_r;
              res.len = last_r;
            end else begin
              res.cmd = CMD_ACK;
              res.blk = cur_r - 16'd1;
            end
          end
        end
      end

      if (fail_v) begin
        mode_nxt = MODE_IDLE;
        aw_nxt   = AW_NONE;
        res_v    = 1'b1;
        res      = '0;
        res.cmd  = CMD_ERROR;
        res.err  = fail_err;
        res.fin  = FIN_FAIL;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_only_r   <= 1'b0;
      max_retries_r <= MAX_RETRIES_RST;
      timeout_r     <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_READ_ONLY:   read_only_r   <= cfg_data[0];
        CFG_MAX_RETRIES: max_retries_r <= cfg_data[3:0];
        CFG_TIMEOUT:     timeout_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r <= in_func;
      op_r   <= in_opcode;
      blk_r  <= in_block_number;
      plen_r <= in_packet_length;
      peer_r <= in_from_peer;
      reqv_r <= in_request_valid;
      ok_r   <= in_file_ok;
      full_r <= in_disk_full;
      rlen_r <= in_read_length;
    end
  end

  // state and result register, updated together when the word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      aw_r    <= AW_NONE;
      cur_r   <= 16'd1;
      retry_r <= '0;
      tick_r  <= '0;
      last_r  <= '0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      aw_r    <= aw_nxt;
      cur_r   <= cur_nxt;
      retry_r <= retry_nxt;
      tick_r  <= tick_nxt;
      last_r  <= last_nxt;
      out_v_r <= s1_v_r && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_v_r && res_v) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_command     = out_r.cmd;
  assign out_out_block   = out_r.blk;
  assign out_send_length = out_r.len;
  assign out_error_code  = out_r.err;
  assign out_to_sender   = out_r.snd;
  assign out_finish      = out_r.fin;

  // a pending file request only exists inside a transfer
  a_aw_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (aw_r != AW_NONE) |-> (mode_r != MODE_IDLE))
    else $error("file request pending while idle");

  // a failing command always leaves the controller idle
  a_fail_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_v_r && res_v && res.fin == FIN_FAIL) |=> (mode_r == MODE_IDLE))
    else $error("failure did not end transfer");

  // DATA is only sent in a read transfer
  a_data_read: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_v_r && res_v && res.cmd == CMD_DATA) |=> (mode_r == MODE_READ))
    else $error("DATA outside read transfer");

  // a stalled word in the input register is never dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |=> s1_v_r)
    else $error("input word lost under stall");

endmodule

[dv/tftp_xfer_checker.sv]
// Checker for the TFTP transfer controller: tracks transfer state and compares command words.
`timescale 1ns / 100ps

module tftp_xfer_checker
  import tftpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_block_number,
  input  logic [9:0]  in_packet_length,
  input  logic        in_from_peer,
  input  logic        in_request_valid,
  input  logic        in_file_ok,
  input  logic        in_disk_full,
  input  logic [9:0]  in_read_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_command,
  input  logic [15:0] out_out_block,
  input  logic [9:0]  out_send_length,
  input  logic [2:0]  out_error_code,
  input  logic        out_to_sender,
  input  logic [1:0]  out_finish,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          awaited
);

  localparam logic [9:0] BLOCK_LEN = 10'(BLOCK_BYTES_DEF);
  localparam logic [9:0] HDR_LEN   = 10'd4;

  // register copies
  logic        ro_q;
  logic [3:0]  retry_limit;
  logic [7:0]  tick_limit;

  // transfer state
  logic [1:0]  xfer_mode;
  logic [2:0]  file_wait;
  logic [15:0] cur_blk;
  logic [3:0]  retries;
  logic [7:0]  ticks;
  logic [9:0]  last_len;

  res_t cmd_queue[$];

  function automatic res_t build(logic [2:0] c, logic [15:0] b, logic [9:0] l,
                                 logic [2:0] e, logic s, logic [1:0] f);
    return '{cmd: c, blk: b, len: l, err: e, snd: s, fin: f};
  endfunction

  // failure ends the transfer and drops any pending file request
  function automatic res_t abandon(logic [2:0] code);
    xfer_mode = MODE_IDLE;
    file_wait = AW_NONE;
    return build(CMD_ERROR, 16'd0, 10'd0, code, 1'b0, FIN_FAIL);
  endfunction

  task automatic begin_transfer(input logic [1:0] m, input logic [2:0] w);
    xfer_mode = m;
    file_wait = w;
    cur_blk   = 16'd1;
    retries   = 4'd0;
    ticks     = 8'd0;
    last_len  = 10'd0;
  endtask

  task automatic advance_transfer(input logic [1:0] fn, input logic [15:0] op,
                                  input logic [15:0] blk, input logic [9:0] plen,
                                  input logic peer, input logic rqv, input logic fok,
                                  input logic full, input logic [9:0] rlen,
                                  output bit hit, output res_t r);
    logic [2:0] was;
    logic [9:0] pay;
    hit = 1'b0;
    r = '0;
    if (fn == FUNC_FILE) begin
      was = file_wait;
      file_wait = AW_NONE;
      hit = (was == AW_OPEN_RD || was == AW_OPEN_WR || was == AW_READ || was == AW_WRITE);
      case (was)
        AW_OPEN_RD: begin
          if (!fok) r = abandon(ERR_NOT_FOUND);
          else begin
            file_wait = AW_READ;
            r = build(CMD_READ, cur_blk, 10'd0, ERR_NONE, 1'b0, FIN_GO);
          end
        end
        AW_OPEN_WR: begin
          if (!fok) r = abandon(ERR_NOT_FOUND);
          else begin
            retries = 4'd0;
            ticks = 8'd0;
            r = build(CMD_ACK, 16'd0, 10'd0, ERR_NONE, 1'b0, FIN_GO);
          end
        end
        AW_READ: begin
          if (!fok) r = abandon(ERR_ACCESS);
          else begin
            last_len = (rlen > BLOCK_LEN) ? BLOCK_LEN : rlen;
            retries = 4'd0;
            ticks = 8'd0;
            r = build(CMD_DATA, cur_blk, last_len, ERR_NONE, 1'b0, FIN_GO);
          end
        end
        AW_WRITE: begin
          if (!fok) r = abandon(full ? ERR_FULL : ERR_ACCESS);
          else begin
            retries = 4'd0;
            ticks = 8'd0;
            if (last_len < BLOCK_LEN) begin
              xfer_mode = MODE_IDLE;
              r = build(CMD_ACK, cur_blk, 10'd0, ERR_NONE, 1'b0, FIN_DONE);
            end else begin
              r = build(CMD_ACK, cur_blk, 10'd0, ERR_NONE, 1'b0, FIN_GO);
              cur_blk = cur_blk + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end else if (file_wait != AW_NONE) begin
      // packets and ticks are dropped while a file reply is due
    end else if (xfer_mode == MODE_IDLE) begin
      if (fn == FUNC_PACKET && plen >= HDR_LEN) begin
        if (op == OP_RRQ || op == OP_WRQ) begin
          hit = 1'b1;
          if (!rqv || (op == OP_WRQ && ro_q))
            r = build(CMD_ERROR, 16'd0, 10'd0, ERR_ACCESS, 1'b0, FIN_FAIL);
          else if (op == OP_RRQ) begin
            begin_transfer(MODE_READ, AW_OPEN_RD);
            r = build(CMD_OPEN_RD, 16'd0, 10'd0, ERR_NONE, 1'b0, FIN_GO);
          end else begin
            begin_transfer(MODE_WRITE, AW_OPEN_WR);
            r = build(CMD_OPEN_WR, 16'd0, 10'd0, ERR_NONE, 1'b0, FIN_GO);
          end
        end else if (op == OP_DATA || op == OP_ACK) begin
          hit = 1'b1;
          r = build(CMD_ERROR, 16'd0, 10'd0, ERR_ACCESS, 1'b0, FIN_GO);
        end else if (op != OP_ERROR) begin
          hit = 1'b1;
          r = build(CMD_ERROR, 16'd0, 10'd0, ERR_ILLEGAL, 1'b0, FIN_GO);
        end
      end
    end else if (fn == FUNC_PACKET) begin
      ticks = 8'd0;
      if (!peer) begin
        hit = 1'b1;
        r = build(CMD_ERROR, 16'd0, 10'd0, ERR_ACCESS, 1'b1, FIN_GO);
      end else if (plen < HDR_LEN) begin
        // runt from the peer only restarts the clock
      end else if (op == OP_ERROR) begin
        xfer_mode = MODE_IDLE;
      end else if (xfer_mode == MODE_READ) begin
        if (op != OP_ACK) begin
          hit = 1'b1;
          r = abandon(ERR_ILLEGAL);
        end else if (blk == cur_blk) begin
          if (last_len < BLOCK_LEN) xfer_mode = MODE_IDLE;
          else begin
            cur_blk = cur_blk + 16'd1;
            file_wait = AW_READ;
            hit = 1'b1;
            r = build(CMD_READ, cur_blk, 10'd0, ERR_NONE, 1'b0, FIN_GO);
          end
        end
      end else begin
        hit = 1'b1;
        if (op != OP_DATA) r = abandon(ERR_ILLEGAL);
        else if (blk == cur_blk) begin
          pay = plen - HDR_LEN;
          if (pay > BLOCK_LEN) pay = BLOCK_LEN;
          last_len = pay;
          file_wait = AW_WRITE;
          r = build(CMD_WRITE, cur_blk, pay, ERR_NONE, 1'b0, FIN_GO);
        end else if (16'(blk + 16'd1) == cur_blk)
          r = build(CMD_ACK, blk, 10'd0, ERR_NONE, 1'b0, FIN_GO);
        else r = abandon(ERR_BAD_BLOCK);
      end
    end else if (fn == FUNC_TICK) begin
      if (ticks != TICK_SAT) ticks = ticks + 8'd1;
      if (ticks >= tick_limit) begin
        ticks = 8'd0;
        if (retries >= retry_limit) xfer_mode = MODE_IDLE;
        else begin
          retries = retries + 4'd1;
          hit = 1'b1;
          if (xfer_mode == MODE_READ)
            r = build(CMD_DATA, cur_blk, last_len, ERR_NONE, 1'b0, FIN_GO);
          else
            r = build(CMD_ACK, 16'(cur_blk - 16'd1), 10'd0, ERR_NONE, 1'b0, FIN_GO);
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t fresh;
    bit   made;
    if (!rst_n) begin
      ro_q        = 1'b0;
      retry_limit = MAX_RETRIES_RST;
      tick_limit  = TIMEOUT_RST;
      begin_transfer(MODE_IDLE, AW_NONE);
      cmd_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cmd_queue.size() == 0) begin
          mismatches++;
          $display("%0t: command word expected none, got cmd %0d blk %0d err %0d",
                   $time, out_command, out_out_block, out_error_code);
        end else begin
          want = cmd_queue.pop_front();
          check_field("command", 16'(want.cmd), 16'(out_command));
          check_field("out_block", want.blk, out_out_block);
          check_field("send_length", 16'(want.len), 16'(out_send_length));
          check_field("error_code", 16'(want.err), 16'(out_error_code));
          check_field("to_sender", 16'(want.snd), 16'(out_to_sender));
          check_field("finish", 16'(want.fin), 16'(out_finish));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READ_ONLY:   ro_q = cfg_data[0];
          CFG_MAX_RETRIES: retry_limit = cfg_data[3:0];
          CFG_TIMEOUT:     tick_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_transfer(in_func, in_opcode, in_block_number, in_packet_length,
                         in_from_peer, in_request_valid, in_file_ok, in_disk_full,
                         in_read_length, made, fresh);
        if (made) cmd_queue.push_back(fresh);
      end
    end
    awaited = cmd_queue.size();
  end

endmodule

[dv/tb_tftp_server_transfer_control.sv]
// Testbench top for the TFTP transfer controller: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_tftp_server_transfer_control;
  import tftpsc_pkg::*;

  localparam int STALL_LIMIT = 3000;   // cycles with no word moving on any channel
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off to back up the input
  localparam int DRAIN_CYCLES = 4;     // lets a word with no command leave the input register
  localparam logic [9:0] FULL_LEN = 10'(BLOCK_BYTES_DEF);
  localparam logic [9:0] FULL_PKT = FULL_LEN + 10'd4;  // header plus a full payload

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [15:0] in_opcode;
  logic [15:0] in_block_number;
  logic [9:0]  in_packet_length;
  logic        in_from_peer;
  logic        in_request_valid;
  logic        in_file_ok;
  logic        in_disk_full;
  logic [9:0]  in_read_length;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_command;
  logic [15:0] out_out_block;
  logic [9:0]  out_send_length;
  logic [2:0]  out_error_code;
  logic        out_to_sender;
  logic [1:0]  out_finish;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int awaited;

  int snd_idle_pct;
  int rcv_idle_pct;
  int words_sent;
  int tmo_ticks;     // effective timeout, used to size tick bursts
  int stall_run;
  logic hold_req;

  tftp_server_transfer_control DUT (.*);

  tftp_xfer_checker u_check (.*, .mismatches(mismatches), .awaited(awaited));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver side: random back-pressure, plus one long hold-off on request.
  // The hold is timed here so the sender keeps pushing words into a full block.
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: a stretch with no word moving anywhere means the block hung.
  always @(posedge clk) begin
    if (!rst_n) stall_run <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_run <= 0;
    else if (stall_run >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else stall_run <= stall_run + 1;
  end

  function automatic bit mostly(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // One input word. Called at a falling edge; returns at the falling edge after
  // the word is taken, leaving valid high so back-to-back words need no gap.
  task automatic put_word(input logic [1:0] fn, input logic [15:0] op,
                          input logic [15:0] blk, input logic [9:0] plen,
                          input logic peer, input logic rqv, input logic fok,
                          input logic full, input logic [9:0] rlen);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= fn;
    in_opcode        <= op;
    in_block_number  <= blk;
    in_packet_length <= plen;
    in_from_peer     <= peer;
    in_request_valid <= rqv;
    in_file_ok       <= fok;
    in_disk_full     <= full;
    in_read_length   <= rlen;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
    words_sent++;
  endtask

  // Packet header word; the file-reply fields are don't-care and randomized.
  task automatic packet(input logic [15:0] op, input logic [15:0] blk,
                        input logic [9:0] plen, input logic peer, input logic rqv);
    put_word(FUNC_PACKET, op, blk, plen, peer, rqv, 1'($urandom), 1'($urandom),
             10'($urandom));
  endtask

  // File-side reply word; packet fields are don't-care and randomized.
  task automatic file_word(input logic fok, input logic full, input logic [9:0] rlen);
    put_word(FUNC_FILE, 16'($urandom), 16'($urandom), 10'($urandom), 1'($urandom),
             1'($urandom), fok, full, rlen);
  endtask

  task automatic tick_burst(input int n);
    repeat (n)
      put_word(FUNC_TICK, 16'($urandom), 16'($urandom), 10'($urandom), 1'($urandom),
               1'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
  endtask

  // Fully random words, including the unused word kind.
  task automatic noise();
    repeat ($urandom_range(3, 10))
      put_word(2'($urandom), 16'($urandom), 16'($urandom), 10'($urandom), 1'($urandom),
               1'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
  endtask

  // Bring the block back to idle from wherever a broken sequence left it:
  // a failing file reply clears a pending request, a peer ERROR ends a transfer.
  task automatic settle();
    file_word(1'b0, 1'($urandom), 10'($urandom));
    packet(OP_ERROR, 16'($urandom), 10'($urandom_range(4, 1023)), 1'b1, 1'($urandom));
  endtask

  // Occasional disruption while the block waits for the peer's next packet.
  task automatic disturb(input logic [15:0] b, input bit wr);
    logic [15:0] dop;
    dop = wr ? OP_DATA : OP_ACK;
    if (!mostly(15)) return;
    case ($urandom_range(6))
      0: tick_burst(($urandom_range(5) == 0) ? tmo_ticks * $urandom_range(1, 3)
                                              : $urandom_range(1, 3));
      // stranger
      1: packet(16'($urandom), 16'($urandom), 10'($urandom_range(4, 1023)), 1'b0,
                1'($urandom));
      // runt from the peer
      2: packet(16'($urandom), 16'($urandom), 10'($urandom_range(0, 3)), 1'b1,
                1'($urandom));
      // duplicate of the previous block: ignored ACK or re-ACKed DATA
      3: packet(dop, b - 16'd1, 10'($urandom_range(4, 1023)), 1'b1, 1'($urandom));
      // arbitrary block number
      4: packet(dop, 16'($urandom), 10'($urandom_range(4, 1023)), 1'b1, 1'($urandom));
      // small opcodes, mostly the wrong one for this direction
      5: packet(16'($urandom_range(0, 8)), b, 10'($urandom_range(4, 1023)), 1'b1,
                1'($urandom));
      default: packet(OP_ERROR, b, 10'($urandom_range(4, 1023)), 1'b1, 1'($urandom));
    endcase
  endtask

  // Read transfer: RRQ, open, then DATA/ACK per block, last block short.
  task automatic read_xfer();
    int nblk;
    nblk = $urandom_range(1, 6);
    settle();
    packet(OP_RRQ, 16'($urandom), 10'($urandom_range(4, 1023)), 1'($urandom), mostly(95));
    file_word(mostly(95), 1'($urandom), 10'($urandom));
    for (int k = 1; k <= nblk; k++) begin
      file_word(mostly(95), 1'($urandom),
                (k == nblk) ? 10'($urandom_range(0, 511))
                            : (mostly(75) ? FULL_LEN : 10'($urandom_range(513, 1023))));
      disturb(16'(k), 1'b0);
      packet(OP_ACK, 16'(k), 10'($urandom_range(4, 1023)), 1'b1, 1'($urandom));
    end
  endtask

  // Write transfer: WRQ, open, then DATA/write reply per block, last block short.
  task automatic write_xfer();
    int nblk;
    nblk = $urandom_range(1, 6);
    settle();
    packet(OP_WRQ, 16'($urandom), 10'($urandom_range(4, 1023)), 1'($urandom), mostly(95));
    file_word(mostly(95), 1'($urandom), 10'($urandom));
    for (int k = 1; k <= nblk; k++) begin
      disturb(16'(k), 1'b1);
      packet(OP_DATA, 16'(k),
             (k == nblk) ? 10'($urandom_range(4, 515))
                         : (mostly(75) ? FULL_PKT : 10'($urandom_range(517, 1023))),
             1'b1, 1'($urandom));
      file_word(mostly(95), 1'($urandom), 10'($urandom));
    end
  endtask

  task automatic random_words(input int target);
    int pick;
    while (words_sent < target) begin
      pick = $urandom_range(9);
      if (pick < 4) read_xfer();
      else if (pick < 8) write_xfer();
      else noise();
    end
  endtask

  // Register write; caller lowers cfg_valid after the last one.
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic set_config(input logic ro, input logic [3:0] rt, input logic [7:0] to);
    cfg_write(CFG_READ_ONLY, {7'd0, ro});
    cfg_write(CFG_MAX_RETRIES, {4'd0, rt});
    cfg_write(CFG_TIMEOUT, to);
    cfg_valid <= 1'b0;
    tmo_ticks = (to == 8'd0) ? 1 : int'(to);   // zero behaves as one
  endtask

  // Stop sending, let every expected command come out, then let any
  // word that makes no command clear the pipe before touching registers.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_PACKET;
    in_opcode        = '0;
    in_block_number  = '0;
    in_packet_length = '0;
    in_from_peer     = 1'b0;
    in_request_valid = 1'b0;
    in_file_ok       = 1'b0;
    in_disk_full     = 1'b0;
    in_read_length   = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_READ_ONLY;
    cfg_data         = '0;
    hold_req         = 1'b0;
    words_sent       = 0;
    snd_idle_pct     = 36;
    rcv_idle_pct     = 52;
    tmo_ticks        = int'(TIMEOUT_RST);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: read-only, no retries, one-tick timeout.
    set_config(1'b1, 4'd0, 8'd1);
    packet(OP_RRQ, 16'd0, 10'd3, 1'b1, 1'b1);            // runt while idle
    packet(OP_RRQ, 16'd0, 10'd4, 1'b0, 1'b0);            // malformed request
    packet(OP_WRQ, 16'hFFFF, 10'd516, 1'b1, 1'b1);       // write refused, read-only
    packet(OP_DATA, 16'd1, 10'd516, 1'b1, 1'b1);         // DATA with no transfer
    packet(OP_ACK, 16'hFFFF, 10'd1023, 1'b0, 1'b0);      // ACK with no transfer
    packet(OP_ERROR, 16'd0, 10'd4, 1'b1, 1'b0);          // ERROR while idle: dropped
    packet(16'hFFFF, 16'd0, 10'd4, 1'b1, 1'b1);          // unknown opcodes
    packet(16'h0000, 16'd0, 10'd4, 1'b1, 1'b1);
    tick_burst(1);                                       // tick while idle
    file_word(1'b1, 1'b1, 10'd512);                      // reply nobody asked for
    put_word(FUNC_SPARE, OP_RRQ, 16'd0, 10'd516, 1'b1, 1'b1, 1'b1, 1'b0, 10'd0);
    packet(OP_RRQ, 16'd0, 10'd1023, 1'b1, 1'b1);         // open fails: not found
    file_word(1'b0, 1'b0, 10'd0);
    packet(OP_RRQ, 16'd0, 10'd4, 1'b1, 1'b1);            // read of a block fails
    file_word(1'b1, 1'b0, 10'd0);
    file_word(1'b0, 1'b1, 10'd0);
    packet(OP_RRQ, 16'd0, 10'd4, 1'b1, 1'b1);
    file_word(1'b1, 1'b0, 10'd0);
    file_word(1'b1, 1'b0, 10'd1023);                     // oversized read saturates
    packet(OP_ACK, 16'd1, 10'd516, 1'b0, 1'b0);          // stranger
    packet(OP_ACK, 16'd1, 10'd2, 1'b1, 1'b0);            // runt from the peer
    packet(OP_ACK, 16'd7, 10'd4, 1'b1, 1'b0);            // ACK of another block
    tick_burst(1);                                       // timeout, no retries left
    packet(OP_ACK, 16'd1, 10'd4, 1'b1, 1'b0);            // transfer is gone by now
    quiesce();

    // Random transfers, sender idles less than the receiver.
    set_config(1'b0, 4'd2, 8'd3);
    random_words(700);
    quiesce();

    // Roles swapped; zero timeout, full retry budget.
    snd_idle_pct = 52;
    rcv_idle_pct = 36;
    set_config(1'b0, 4'd15, 8'd0);
    random_words(1400);
    quiesce();

    // Full rate with a long receiver hold-off at the start.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(1'b1, 4'd1, 8'd255);
    hold_req <= 1'b1;
    random_words(2000);
    quiesce();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tftpsc_pkg.sv
hw/rtl/tftp_server_transfer_control.sv
dv/tftp_xfer_checker.sv
dv/tb_tftp_server_transfer_control.sv
